FILE: rtl/pec_pkg.sv
// Shared constants, types, command bundle and elaboration-time tables of the compressor.
package pec_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int LOG_TABLE_BITS = 8;
  localparam int TBL_N          = 1 << LOG_TABLE_BITS;
  localparam int FRAC_SH        = 16 - LOG_TABLE_BITS;
  localparam int POS_W          = $clog2(SAMPLE_BITS);
  localparam int LG_W           = 23;
  localparam int RED_W          = LG_W + 17 - 16;
  localparam int TOT_W          = 20;

  localparam logic [2:0] REG_ATTACK    = 3'd0;
  localparam logic [2:0] REG_RELEASE   = 3'd1;
  localparam logic [2:0] REG_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_SLOPE     = 3'd3;
  localparam logic [2:0] REG_MAKEUP    = 3'd4;
  localparam logic [2:0] REG_CHANNELS  = 3'd5;

  typedef logic [16:0] tab_t [TBL_N+1];

  typedef struct packed {
    logic [15:0]        attack_coef;
    logic [15:0]        release_coef;
    logic signed [21:0] threshold_log2;
    logic signed [16:0] comp_slope;
    logic [19:0]        makeup_gain;
    logic [1:0]         channel_count;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic env_mul_a;
    logic env_mul_b;
    logic env_upd;
    logic log_norm;
    logic log_fin;
    logic red;
    logic exp;
    logic tot;
    logic scale_a;
    logic scale_b;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic env_zero;
    logic above;
  } stat_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bt;
    x   = x_in;
    res = 64'd0;
    bt  = 64'd1 << 62;
    for (int n = 0; n < 32; n++) begin
      if (bt > x) bt = bt >> 2;
    end
    for (int n = 0; n < 32; n++) begin
      if (bt != 64'd0) begin
        if (x >= res + bt) begin
          x   = x - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // log2(1 + i/N) in Q16 by repeated squaring, truncated
  function automatic tab_t build_log();
    tab_t        t;
    logic [63:0] m;
    logic [31:0] acc;
    for (int i = 0; i < TBL_N; i++) begin
      m   = 64'(TBL_N + i) << (30 - LOG_TABLE_BITS);
      acc = 32'd0;
      for (int b = 0; b < 16; b++) begin
        m   = (m * m) >> 30;
        acc = acc << 1;
        if (m >= (64'd1 << 31)) begin
          acc = acc | 32'd1;
          m   = m >> 1;
        end
      end
      t[i] = 17'(acc);
    end
    t[TBL_N] = 17'd65536;
    return t;
  endfunction

  // 2^-(i/N) in Q16
  function automatic tab_t build_exp();
    tab_t        t;
    logic [63:0] roots [LOG_TABLE_BITS];
    logic [63:0] acc;
    roots[0] = isqrt64(64'd1 << 59);
    for (int b = 1; b < LOG_TABLE_BITS; b++) roots[b] = isqrt64(roots[b-1] << 30);
    for (int i = 0; i < TBL_N; i++) begin
      acc = 64'd1 << 30;
      for (int b = 0; b < LOG_TABLE_BITS; b++) begin
        if (((i >> (LOG_TABLE_BITS - 1 - b)) & 1) != 0)
          acc = (acc * roots[b] + (64'd1 << 29)) >> 30;
      end
      t[i] = 17'((acc + (64'd1 << 13)) >> 14);
    end
    t[TBL_N] = 17'd32768;
    return t;
  endfunction

  localparam tab_t LOG_TAB = build_log();
  localparam tab_t EXP_TAB = build_exp();

endpackage

FILE: rtl/pec_ctrl.sv
// Sequencer of the compressor: steps one frame through the datapath and owns the output beat.
module pec_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  pec_pkg::stat_t stat,
  output pec_pkg::cmd_t  cmd
);
  import pec_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ENVA = 4'd1;
  localparam logic [3:0] S_ENVB = 4'd2;
  localparam logic [3:0] S_ENVU = 4'd3;
  localparam logic [3:0] S_LOGN = 4'd4;
  localparam logic [3:0] S_LOGF = 4'd5;
  localparam logic [3:0] S_RED  = 4'd6;
  localparam logic [3:0] S_EXP  = 4'd7;
  localparam logic [3:0] S_TOT  = 4'd8;
  localparam logic [3:0] S_SCA  = 4'd9;
  localparam logic [3:0] S_SCB  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_ENVA;
        end
      end
      S_ENVA: begin
        cmd.env_mul_a = 1'b1;
        state_next    = S_ENVB;
      end
      S_ENVB: begin
        cmd.env_mul_b = 1'b1;
        state_next    = S_ENVU;
      end
      S_ENVU: begin
        cmd.env_upd = 1'b1;
        state_next  = S_LOGN;
      end
      S_LOGN: begin
        cmd.log_norm = 1'b1;
        state_next   = stat.env_zero ? S_TOT : S_LOGF;
      end
      S_LOGF: begin
        cmd.log_fin = 1'b1;
        state_next  = stat.above ? S_RED : S_TOT;
      end
      S_RED: begin
        cmd.red    = 1'b1;
        state_next = S_EXP;
      end
      S_EXP: begin
        cmd.exp    = 1'b1;
        state_next = S_TOT;
      end
      S_TOT: begin
        cmd.tot    = 1'b1;
        state_next = S_SCA;
      end
      S_SCA: begin
        cmd.scale_a = 1'b1;
        state_next  = S_SCB;
      end
      S_SCB: begin
        cmd.scale_b = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: rtl/pec_datapath.sv
// Datapath of the compressor: envelope, log2, gain law, makeup and sample scaling.
module pec_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  pec_pkg::cfg_t                          cfg,
  input  pec_pkg::cmd_t                          cmd,
  output pec_pkg::stat_t                         stat,
  input  logic signed [pec_pkg::SAMPLE_BITS-1:0] sample_a,
  input  logic signed [pec_pkg::SAMPLE_BITS-1:0] sample_b,
  input  logic                                   first_of_buffer,
  output logic signed [pec_pkg::SAMPLE_BITS-1:0] out_a,
  output logic signed [pec_pkg::SAMPLE_BITS-1:0] out_b,
  output logic [pec_pkg::TOT_W-1:0]              total_gain,
  output logic                                   reducing
);
  import pec_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam logic signed [LG_W-1:0] LG_BIAS = LG_W'((SB - 1) * 65536);
  localparam logic [SB-1:0] MAXV = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB:0]   MINM = {2'b01, {(SB-1){1'b0}}};
  localparam logic [FRAC_SH:0] HALF = (FRAC_SH+1)'(1 << (FRAC_SH - 1));

  logic signed [SB-1:0]   sa, sb;
  logic [SB-1:0]          peak, envelope;
  logic [15:0]            coef;
  logic [SB+15:0]         prod_a;
  logic [SB+16:0]         prod_b;
  logic [POS_W-1:0]       lpos;
  logic [FRAC_SH-1:0]     lrem;
  logic [16:0]            tlo, thi;
  logic signed [LG_W-1:0] lg;
  logic [RED_W-1:0]       red;
  logic [16:0]            gain;
  logic [TOT_W-1:0]       total;
  logic signed [SB-1:0]   qa, qb;
  logic                   red_flag;

  // input side
  logic              stereo;
  logic [SB-1:0]     mag_a_in, mag_b_in;
  logic signed [SB-1:0] sb_in;

  assign stereo   = cfg.channel_count[1];
  assign sb_in    = stereo ? sample_b : '0;
  assign mag_a_in = sample_a[SB-1] ? SB'(-sample_a) : SB'(sample_a);
  assign mag_b_in = sb_in[SB-1] ? SB'(-sb_in) : SB'(sb_in);

  // envelope
  logic [15:0]    coef_sel;
  logic [SB+16:0] env_sum;
  assign coef_sel = (peak > envelope) ? cfg.attack_coef : cfg.release_coef;
  assign env_sum  = (SB+17)'(prod_a) + prod_b + (SB+17)'(32768);

  // leading one and normalisation
  logic [POS_W-1:0]  p_c;
  logic [SB+15:0]    norm;
  logic [15:0]       frac;
  logic [LOG_TABLE_BITS-1:0] lidx;
  always_comb begin
    p_c = '0;
    for (int i = 0; i < SB; i++) begin
      if (envelope[i]) p_c = POS_W'(i);
    end
  end
  assign norm = {envelope, 16'b0} << (POS_W'(SB - 1) - p_c);
  assign frac = norm[SB+14 -: 16];
  assign lidx = frac[15 -: LOG_TABLE_BITS];

  // log finish and threshold compare
  logic [16:0]            ldiff;
  logic [16+FRAC_SH:0]    lprod;
  logic [16:0]            interp;
  logic signed [LG_W-1:0] lg_c, th_e;
  assign ldiff  = thi - tlo;
  assign lprod  = (17+FRAC_SH)'(ldiff * lrem) + (17+FRAC_SH)'(HALF);
  assign interp = tlo + 17'(lprod >> FRAC_SH);
  assign th_e   = LG_W'(cfg.threshold_log2);
  assign lg_c   = $signed(LG_W'({lpos, 16'b0})) + $signed(LG_W'(interp)) - LG_BIAS;

  assign stat.env_zero = (envelope == '0);
  assign stat.above    = (lg_c > th_e);

  // reduction amount
  logic [LG_W-1:0]        over;
  logic [16:0]            neg;
  logic [LG_W+16:0]       rprod;
  assign over  = LG_W'(lg - th_e);
  assign neg   = cfg.comp_slope[16] ? 17'(-cfg.comp_slope) : 17'd0;
  assign rprod = (LG_W+17)'(over * neg) + (LG_W+17)'(32768);

  // exp2 of the negated reduction
  logic [7:0]                k;
  logic [15:0]               f;
  logic [LOG_TABLE_BITS-1:0] eidx;
  logic [FRAC_SH-1:0]        erem;
  logic [16:0]               ehi, elo, ediff, v;
  logic [16+FRAC_SH:0]       eprod;
  logic [21:0]               vr;
  logic [16:0]               gain_c;
  assign k     = 8'(red >> 16);
  assign f     = red[15:0];
  assign eidx  = f[15 -: LOG_TABLE_BITS];
  assign erem  = f[FRAC_SH-1:0];
  assign ehi   = EXP_TAB[eidx];
  assign elo   = EXP_TAB[(LOG_TABLE_BITS+1)'(eidx) + 1'b1];
  assign ediff = ehi - elo;
  assign eprod = (17+FRAC_SH)'(ediff * erem) + (17+FRAC_SH)'(HALF);
  assign v     = ehi - 17'(eprod >> FRAC_SH);
  assign vr    = 22'(v) + (22'd1 << (5'(k) - 5'd1));
  always_comb begin
    priority if (k == 8'd0) gain_c = v;
    else if (k > 8'd20)     gain_c = 17'd0;
    else                    gain_c = 17'(vr >> k[4:0]);
  end

  // makeup
  logic [36:0] tprod;
  logic [20:0] tq;
  assign tprod = 37'(gain * cfg.makeup_gain) + 37'd32768;
  assign tq    = 21'(tprod >> 16);

  // sample scaling, one channel per step
  logic signed [SB-1:0] s_sel;
  logic [SB-1:0]        s_mag;
  logic [SB+TOT_W-1:0]  sprod;
  logic [SB+4:0]        q;
  logic signed [SB-1:0] q_sat;
  assign s_sel = cmd.scale_b ? sb : sa;
  assign s_mag = s_sel[SB-1] ? SB'(-s_sel) : SB'(s_sel);
  assign sprod = (SB+TOT_W)'(s_mag * total) + (SB+TOT_W)'(32768);
  assign q     = (SB+5)'(sprod >> 16);
  always_comb begin
    if (s_sel[SB-1]) q_sat = (q > (SB+5)'(MINM)) ? $signed(MINM[SB-1:0]) : SB'(-q);
    else             q_sat = (q > (SB+5)'(MAXV)) ? $signed(MAXV) : SB'(q);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sa       <= sample_a;
      sb       <= sb_in;
      peak     <= (mag_a_in > mag_b_in) ? mag_a_in : mag_b_in;
      gain     <= 17'd65536;
      red_flag <= 1'b0;
    end
    if (cmd.env_mul_a) begin
      coef   <= coef_sel;
      prod_a <= (SB+16)'(coef_sel * envelope);
    end
    if (cmd.env_mul_b) prod_b <= (SB+17)'((17'd65536 - 17'(coef)) * peak);
    if (cmd.log_norm) begin
      lpos <= p_c;
      lrem <= frac[FRAC_SH-1:0];
      tlo  <= LOG_TAB[lidx];
      thi  <= LOG_TAB[(LOG_TABLE_BITS+1)'(lidx) + 1'b1];
    end
    if (cmd.log_fin) begin
      lg       <= lg_c;
      red_flag <= stat.above;
    end
    if (cmd.red)     red   <= RED_W'(rprod >> 16);
    if (cmd.exp)     gain  <= gain_c;
    if (cmd.tot)     total <= tq[20] ? {TOT_W{1'b1}} : tq[TOT_W-1:0];
    if (cmd.scale_a) qa    <= q_sat;
    if (cmd.scale_b) qb    <= q_sat;
    if (cmd.out_load) begin
      out_a      <= qa;
      out_b      <= qb;
      total_gain <= total;
      reducing   <= red_flag;
    end
  end

  // envelope is state: cleared by reset and at the first frame of a buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      envelope <= '0;
    end else if (cmd.load && first_of_buffer) begin
      envelope <= '0;
    end else if (cmd.env_upd) begin
      envelope <= SB'(env_sum >> 16);
    end
  end

endmodule

FILE: rtl/peak_envelope_compressor.sv
// Peak-envelope compressor: one result beat per frame of one or two channels.
// A frame is taken when in_ready is high and its beat reaches the output register after the
// sequencer steps through envelope, log2, reduction, exp2, makeup and scaling; log2 finish is
// skipped when the envelope is zero, and reduction and exp2 when it is at or below threshold.
// The sequencer returns to idle as the beat is loaded, and a new frame is taken only then,
// since the envelope multiplies, log2, gain and per-channel scaling step through one datapath.
// A beat still waiting in the output register holds the sequencer in its last step until
// out_ready, while it already processes the next frame up to that step. Registers sit on an
// APB port at byte offsets 0,4,..,20: attack, release, threshold (log2 Q5.16), slope (Q0.16),
// makeup (Q4.16), channel count.
module peak_envelope_compressor (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [4:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [pec_pkg::SAMPLE_BITS-1:0] sample_a,
  input  logic signed [pec_pkg::SAMPLE_BITS-1:0] sample_b,
  input  logic                                   first_of_buffer,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [pec_pkg::SAMPLE_BITS-1:0] out_a,
  output logic signed [pec_pkg::SAMPLE_BITS-1:0] out_b,
  output logic [pec_pkg::TOT_W-1:0]              total_gain,
  output logic                                   reducing
);
  import pec_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  stat_t      stat;
  logic       wr;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_coef    <= '0;
      cfg.release_coef   <= '0;
      cfg.threshold_log2 <= '0;
      cfg.comp_slope     <= '0;
      cfg.makeup_gain    <= 20'd65536;
      cfg.channel_count  <= 2'd2;
    end else if (wr) begin
      unique case (ridx)
        REG_ATTACK:    cfg.attack_coef    <= pwdata[15:0];
        REG_RELEASE:   cfg.release_coef   <= pwdata[15:0];
        REG_THRESHOLD: cfg.threshold_log2 <= pwdata[21:0];
        REG_SLOPE:     cfg.comp_slope     <= pwdata[16:0];
        REG_MAKEUP:    cfg.makeup_gain    <= pwdata[19:0];
        REG_CHANNELS:  cfg.channel_count  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_ATTACK:    prdata = 32'(cfg.attack_coef);
      REG_RELEASE:   prdata = 32'(cfg.release_coef);
      REG_THRESHOLD: prdata = 32'(cfg.threshold_log2);
      REG_SLOPE:     prdata = 32'(cfg.comp_slope);
      REG_MAKEUP:    prdata = 32'(cfg.makeup_gain);
      REG_CHANNELS:  prdata = 32'(cfg.channel_count);
      default:       prdata = 32'd0;
    endcase
  end

  pec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pec_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .stat            (stat),
    .sample_a        (sample_a),
    .sample_b        (sample_b),
    .first_of_buffer (first_of_buffer),
    .out_a           (out_a),
    .out_b           (out_b),
    .total_gain      (total_gain),
    .reducing        (reducing)
  );

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the peak-envelope compressor: random frames, APB setup, scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import pec_pkg::*;

  typedef struct packed {
    logic signed [23:0] a;
    logic signed [23:0] b;
    logic               first;
  } frame_t;

  typedef struct packed {
    logic signed [23:0] a;
    logic signed [23:0] b;
    logic [19:0]        gain;
    logic               red;
  } gained_t;

  localparam int FLUSH_CYCLES = 40;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic signed [23:0] sample_a = '0, sample_b = '0;
  logic first_of_buffer = 1'b0;
  logic out_valid, out_ready = 1'b0;
  logic signed [23:0] out_a, out_b;
  logic [19:0] total_gain;
  logic reducing;

  peak_envelope_compressor u_dut (.*);

  // model state
  logic [15:0] m_attack, m_release;
  logic signed [21:0] m_thresh;
  logic signed [16:0] m_slope;
  logic [19:0] m_makeup;
  logic [1:0] m_chans;
  logic [23:0] m_env;
  logic [31:0] lg_tab [TBL_N+1];
  logic [31:0] ex_tab [TBL_N+1];

  frame_t pending_frames[$];
  gained_t expected_gains[$];
  int send_idle_pct, recv_idle_pct;
  bit hold_send;
  int mismatches, frames_sent, beats_seen;
  longint cycles;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else r >>= 1;
      bt >>= 2;
    end
    return r;
  endfunction

  task automatic make_tables();
    logic [63:0] m, acc;
    logic [63:0] rt [LOG_TABLE_BITS];
    for (int i = 0; i < TBL_N; i++) begin
      m = 64'(TBL_N + i) << (30 - LOG_TABLE_BITS);
      acc = 0;
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 30;
        acc <<= 1;
        if (m >= (64'd1 << 31)) begin
          acc |= 1;
          m >>= 1;
        end
      end
      lg_tab[i] = acc[31:0];
    end
    lg_tab[TBL_N] = 65536;
    rt[0] = int_sqrt(64'd1 << 59);
    for (int k = 1; k < LOG_TABLE_BITS; k++) rt[k] = int_sqrt(rt[k-1] << 30);
    for (int i = 0; i < TBL_N; i++) begin
      acc = 64'd1 << 30;
      for (int k = 0; k < LOG_TABLE_BITS; k++)
        if ((i >> (LOG_TABLE_BITS - 1 - k)) & 1) acc = (acc * rt[k] + (64'd1 << 29)) >> 30;
      ex_tab[i] = 32'((acc + (64'd1 << 13)) >> 14);
    end
    ex_tab[TBL_N] = 32768;
  endtask

  function automatic longint env_log2(logic [23:0] e);
    int p;
    logic [31:0] fr, idx, rem, lo, hi;
    p = 23;
    while (p > 0 && !e[p]) p--;
    fr = (p >= 16) ? 32'((e >> (p - 16)) & 24'hFFFF) : 32'((32'(e) << (16 - p)) & 32'hFFFF);
    idx = fr >> FRAC_SH;
    rem = fr & ((1 << FRAC_SH) - 1);
    lo = lg_tab[idx];
    hi = lg_tab[idx+1];
    lo += ((hi - lo) * rem + ((1 << FRAC_SH) >> 1)) >> FRAC_SH;
    return longint'(p - 23) * 65536 + longint'(lo);
  endfunction

  function automatic logic [63:0] gain_from_reduction(logic [63:0] r);
    logic [63:0] k, v, hi, lo, f, idx, rem;
    k = r >> 16;
    f = r & 64'hFFFF;
    idx = f >> FRAC_SH;
    rem = f & ((1 << FRAC_SH) - 1);
    hi = ex_tab[idx];
    lo = ex_tab[idx+1];
    v = hi - (((hi - lo) * rem + ((1 << FRAC_SH) >> 1)) >> FRAC_SH);
    if (k == 0) return v;
    if (k > 20) return 0;
    return (v + (64'd1 << (k - 1))) >> k;
  endfunction

  function automatic logic [23:0] apply_gain(longint s, logic [63:0] g);
    logic [63:0] mag, q;
    mag = s < 0 ? -s : s;
    q = (mag * g + 32768) >> 16;
    if (s < 0) return (q > 64'd8388608) ? 24'h800000 : 24'(-longint'(q));
    return (q > 64'd8388607) ? 24'h7FFFFF : 24'(q);
  endfunction

  function automatic gained_t compress_frame(frame_t f);
    gained_t r;
    bit stereo;
    longint sa, sb, lg, th;
    logic [63:0] pa, pb, pk, cf, g, tot, over, neg, e;
    stereo = m_chans >= 2;
    sa = f.a;
    sb = stereo ? longint'(f.b) : 0;
    pa = sa < 0 ? -sa : sa;
    pb = sb < 0 ? -sb : sb;
    pk = pa > pb ? pa : pb;
    g = 65536;
    r.red = 1'b0;
    if (f.first) m_env = 0;
    e = m_env;
    cf = pk > e ? m_attack : m_release;
    m_env = 24'((cf * e + (65536 - cf) * pk + 32768) >> 16);
    if (m_env > 0) begin
      lg = env_log2(m_env);
      th = m_thresh;
      if (lg > th) begin
        over = lg - th;
        neg = m_slope < 0 ? 64'(-longint'(m_slope)) : 0;
        r.red = 1'b1;
        g = gain_from_reduction((over * neg + 32768) >> 16);
      end
    end
    tot = (g * m_makeup + 32768) >> 16;
    if (tot > 64'hFFFFF) tot = 64'hFFFFF;
    r.gain = tot[19:0];
    r.a = apply_gain(sa, tot);
    r.b = stereo ? apply_gain(sb, tot) : 24'd0;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // frame driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_frames.size() > 0 && !hold_send && $urandom_range(99) >= send_idle_pct) begin
        frame_t f;
        f = pending_frames.pop_front();
        expected_gains.push_back(compress_frame(f));
        sample_a <= f.a;
        sample_b <= f.b;
        first_of_buffer <= f.first;
        in_valid <= 1'b1;
        frames_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst) begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        beats_seen++;
        if (expected_gains.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: %h %h %h %b",
                                         out_a, out_b, total_gain, reducing);
        end else begin
          gained_t x;
          x = expected_gains.pop_front();
          if (out_a !== x.a || out_b !== x.b || total_gain !== x.gain || reducing !== x.red)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch beat %0d: exp a=%h b=%h g=%h r=%b got a=%h b=%h g=%h r=%b",
                       beats_seen, x.a, x.b, x.gain, x.red, out_a, out_b, total_gain, reducing);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d beats outstanding", expected_gains.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ATTACK:    m_attack = v[15:0];
      REG_RELEASE:   m_release = v[15:0];
      REG_THRESHOLD: m_thresh = v[21:0];
      REG_SLOPE:     m_slope = v[16:0];
      REG_MAKEUP:    m_makeup = v[19:0];
      REG_CHANNELS:  m_chans = v[1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_frames.size() > 0 || expected_gains.size() > 0 || in_valid) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  task automatic setup(logic [15:0] at, logic [15:0] rl, int th, int sl,
                       logic [19:0] mk, logic [1:0] ch);
    reg_write(REG_ATTACK, at);
    reg_write(REG_RELEASE, rl);
    reg_write(REG_THRESHOLD, 32'(th));
    reg_write(REG_SLOPE, 32'(sl));
    reg_write(REG_MAKEUP, mk);
    reg_write(REG_CHANNELS, ch);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(255)) - 24'd128;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic queue_random(int n);
    frame_t f;
    for (int i = 0; i < n; i++) begin
      f.a = rand_sample();
      f.b = rand_sample();
      f.first = ($urandom_range(15) == 0);
      pending_frames.push_back(f);
    end
  endtask

  initial begin
    frame_t f;
    m_attack = 0; m_release = 0; m_thresh = 0; m_slope = 0;
    m_makeup = 65536; m_chans = 2; m_env = 0;
    make_tables();
    send_idle_pct = 14; recv_idle_pct = 63;
    hold_send = 0; mismatches = 0; frames_sent = 0; beats_seen = 0; cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, then heavy compression on extremes
    f = '{a: 24'h7FFFFF, b: 24'h800000, first: 1'b1}; pending_frames.push_back(f);
    f = '{a: 24'h000000, b: 24'h000000, first: 1'b0}; pending_frames.push_back(f);
    drain();
    setup(16'd0, 16'hFFFF, -1572864, -65536, 20'hFFFFF, 2'd2);
    f = '{a: 24'h000000, b: 24'h000000, first: 1'b1}; pending_frames.push_back(f);
    f = '{a: 24'h000001, b: 24'hFFFFFF, first: 1'b0}; pending_frames.push_back(f);
    f = '{a: 24'h800000, b: 24'h7FFFFF, first: 1'b0}; pending_frames.push_back(f);
    f = '{a: 24'h400000, b: 24'hC00000, first: 1'b0}; pending_frames.push_back(f);
    f = '{a: 24'h000010, b: 24'h000000, first: 1'b1}; pending_frames.push_back(f);
    // let a few frames go, then pause the sender until every beat is back
    while (pending_frames.size() > 2) @(posedge clk);
    hold_send = 1;
    while (expected_gains.size() > 0 || in_valid) @(posedge clk);
    hold_send = 0;
    drain();
    // mono, positive slope (ignored), threshold at full scale
    setup(16'hFFFF, 16'd0, 0, 65535, 20'd0, 2'd1);
    f = '{a: 24'h7FFFFF, b: 24'h123456, first: 1'b1}; pending_frames.push_back(f);
    f = '{a: 24'h800000, b: 24'h7FFFFF, first: 1'b0}; pending_frames.push_back(f);
    drain();
    setup(16'h8000, 16'hF000, -400000, -32768, 20'h30000, 2'd0);
    f = '{a: 24'h7FFFFF, b: 24'h7FFFFF, first: 1'b0}; pending_frames.push_back(f);
    f = '{a: 24'hFF0000, b: 24'h000000, first: 1'b0}; pending_frames.push_back(f);
    drain();
    reg_write(REG_CHANNELS, 2'd3);
    f = '{a: 24'h000100, b: 24'h800000, first: 1'b0}; pending_frames.push_back(f);
    drain();

    // random phases across settings and idling mixes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        2: begin send_idle_pct = 63; recv_idle_pct = 14; end
        4: begin send_idle_pct = 0; recv_idle_pct = 0; end
        default: ;
      endcase
      setup(16'($urandom), 16'($urandom), -int'($urandom_range(1572864)),
            -int'($urandom_range(65536)), 20'($urandom_range(20'h40000)),
            2'($urandom_range(1, 3)));
      queue_random(90);
      drain();
    end

    $display("covered %0d frames, %0d beats checked: directed extremes, then six random settings",
             frames_sent, beats_seen);
    $display("idling mixes sender/receiver 14/63, 63/14 and 0/0, one full sender pause");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
